### src/bssc_pkg.sv
// Shared types and constants of the bounded subset-sum engine.
// Used by the controller, datapath and top level; depends on nothing.
package bssc_pkg;

    localparam int FIELD_W = 13;
    localparam int PW_W    = FIELD_W + 1;
    localparam int PROD_W  = PW_W + FIELD_W;
    localparam int WORD_W  = 64;
    localparam int WORD_SH = 6;
    localparam int CFG_W   = 32;
    localparam int ADDR_W  = 3;

    localparam logic REG_TARGET_SUM = 1'b0;

    typedef enum logic [3:0] {
        S_CLR_INIT,
        S_CLEAR,
        S_IDLE,
        S_SPLIT,
        S_MUL,
        S_CHECK,
        S_PRIME,
        S_RUN,
        S_DRAIN,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_REPORT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SPLIT,
        OP_MUL,
        OP_CHECK,
        OP_PRIME,
        OP_RUN,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_CLR_INIT,
        OP_CLR
    } t_op;

    typedef struct packed {
        logic have_chunk;
        logic chunk_ok;
        logic run_last;
        logic found;
        logic clr_last;
        logic last;
    } t_sts;

endpackage

### src/bounded_subset_sum_closest.sv
// Bounded subset-sum engine: splits each group into doubling chunks and a remainder and
// sweeps the reachability store row by row (64 sums per row) once per chunk, one row a cycle.
// Chunks larger than the target are skipped; the store is then scanned row by row down
// from the target row for the best sum. One request in flight at a time.
// Reset and a last group start a clearing pass over all MAX_SUM/64+1 rows (65 by default).
// The result strobe lasts one cycle and cannot be held off; config writes are always taken.
module bounded_subset_sum_closest #(
    parameter int MAX_SUM = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [bssc_pkg::FIELD_W-1:0]    i_item_size,
    input  logic [bssc_pkg::FIELD_W-1:0]    i_item_count,
    input  logic                            i_last_group,
    output logic                            o_done,
    output logic [bssc_pkg::FIELD_W-1:0]    o_best_sum,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bssc_pkg::ADDR_W-1:0]     paddr,
    input  logic [bssc_pkg::CFG_W-1:0]      pwdata,
    output logic [bssc_pkg::CFG_W-1:0]      prdata,
    output logic                            pready
);

    logic [bssc_pkg::FIELD_W-1:0] r_target;
    logic                         cfg_wr;
    bssc_pkg::t_op                op;
    bssc_pkg::t_sts               sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == bssc_pkg::REG_TARGET_SUM);
    assign prdata = (paddr[2] == bssc_pkg::REG_TARGET_SUM) ?
                    bssc_pkg::CFG_W'(r_target) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (cfg_wr) begin
            r_target <= pwdata[bssc_pkg::FIELD_W-1:0];
        end
    end

    bssc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_op    (op),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    bssc_dp #(
        .MAX_SUM (MAX_SUM)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_item_size  (i_item_size),
        .i_item_count (i_item_count),
        .i_last_group (i_last_group),
        .i_target     (r_target),
        .o_sts        (sts),
        .o_best_sum   (o_best_sum)
    );

endmodule

### src/bssc_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
module bssc_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 65,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    output logic [WIDTH-1:0]  o_rdata_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### src/bssc_ctrl.sv
// Sequencer of the subset-sum engine: chunk loop, row sweep, scan, clear pass.
// Depends on bssc_pkg; drives the datapath through t_op, reads t_sts.
module bssc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  bssc_pkg::t_sts  i_sts,
    output bssc_pkg::t_op   o_op,
    output logic            o_busy,
    output logic            o_done
);

    bssc_pkg::t_state r_state;
    bssc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bssc_pkg::S_CLR_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bssc_pkg::S_CLR_INIT: n_state = bssc_pkg::S_CLEAR;
            bssc_pkg::S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = bssc_pkg::S_IDLE;
                end
            end
            bssc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = bssc_pkg::S_SPLIT;
                end
            end
            bssc_pkg::S_SPLIT: begin
                n_state = i_sts.have_chunk ? bssc_pkg::S_MUL : bssc_pkg::S_SCAN_RD;
            end
            bssc_pkg::S_MUL:   n_state = bssc_pkg::S_CHECK;
            bssc_pkg::S_CHECK: begin
                n_state = i_sts.chunk_ok ? bssc_pkg::S_PRIME : bssc_pkg::S_SPLIT;
            end
            bssc_pkg::S_PRIME: n_state = bssc_pkg::S_RUN;
            bssc_pkg::S_RUN: begin
                if (i_sts.run_last) begin
                    n_state = bssc_pkg::S_DRAIN;
                end
            end
            bssc_pkg::S_DRAIN:   n_state = bssc_pkg::S_SPLIT;
            bssc_pkg::S_SCAN_RD: n_state = bssc_pkg::S_SCAN_CHK;
            bssc_pkg::S_SCAN_CHK: begin
                n_state = i_sts.found ? bssc_pkg::S_REPORT : bssc_pkg::S_SCAN_RD;
            end
            bssc_pkg::S_REPORT: begin
                n_state = i_sts.last ? bssc_pkg::S_CLR_INIT : bssc_pkg::S_IDLE;
            end
            default: n_state = bssc_pkg::S_CLR_INIT;
        endcase
    end

    always_comb begin
        o_op   = bssc_pkg::OP_NONE;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            bssc_pkg::S_CLR_INIT: o_op = bssc_pkg::OP_CLR_INIT;
            bssc_pkg::S_CLEAR:    o_op = bssc_pkg::OP_CLR;
            bssc_pkg::S_IDLE: begin
                o_busy = 1'b0;
                o_op   = i_start ? bssc_pkg::OP_LOAD : bssc_pkg::OP_NONE;
            end
            bssc_pkg::S_SPLIT:    o_op = bssc_pkg::OP_SPLIT;
            bssc_pkg::S_MUL:      o_op = bssc_pkg::OP_MUL;
            bssc_pkg::S_CHECK:    o_op = bssc_pkg::OP_CHECK;
            bssc_pkg::S_PRIME:    o_op = bssc_pkg::OP_PRIME;
            bssc_pkg::S_RUN:      o_op = bssc_pkg::OP_RUN;
            bssc_pkg::S_DRAIN:    o_op = bssc_pkg::OP_NONE;
            bssc_pkg::S_SCAN_RD:  o_op = bssc_pkg::OP_SCAN_RD;
            bssc_pkg::S_SCAN_CHK: o_op = bssc_pkg::OP_SCAN_CHK;
            bssc_pkg::S_REPORT:   o_done = 1'b1;
            default:              o_op = bssc_pkg::OP_NONE;
        endcase
    end

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_run_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bssc_pkg::S_RUN) |->
            ($past(r_state) == bssc_pkg::S_PRIME || $past(r_state) == bssc_pkg::S_RUN))
        else $error("row sweep entered without priming the source row");

    a_report_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == bssc_pkg::S_SCAN_CHK && $past(i_sts.found)))
        else $error("result reported without a completed scan");

endmodule

### src/bssc_dp.sv
// Datapath of the subset-sum engine: chunk split, row-wise shift-OR, scan, clear.
// Depends on bssc_pkg and bssc_ram; controlled by t_op, reports t_sts.
module bssc_dp #(
    parameter int MAX_SUM = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bssc_pkg::t_op                   i_op,
    input  logic [bssc_pkg::FIELD_W-1:0]    i_item_size,
    input  logic [bssc_pkg::FIELD_W-1:0]    i_item_count,
    input  logic                            i_last_group,
    input  logic [bssc_pkg::FIELD_W-1:0]    i_target,
    output bssc_pkg::t_sts                  o_sts,
    output logic [bssc_pkg::FIELD_W-1:0]    o_best_sum
);

    localparam int SUM_W = $clog2(MAX_SUM + 1);
    localparam int CMP_W = (SUM_W > bssc_pkg::FIELD_W) ? SUM_W : bssc_pkg::FIELD_W;
    localparam int ROWS  = MAX_SUM / bssc_pkg::WORD_W + 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int W     = bssc_pkg::WORD_W;
    localparam int SH    = bssc_pkg::WORD_SH;

    logic [bssc_pkg::FIELD_W-1:0] r_size;
    logic [bssc_pkg::FIELD_W-1:0] r_count;
    logic [bssc_pkg::PW_W-1:0]    r_pw;
    logic [bssc_pkg::PW_W-1:0]    r_factor;
    logic [bssc_pkg::PROD_W-1:0]  r_chunk;
    logic                         r_last;
    logic [CMP_W-1:0]             r_t;
    logic [ROW_W-1:0]             r_q;
    logic [SH-1:0]                r_s;
    logic [ROW_W-1:0]             r_k;
    logic [W-1:0]                 r_hi;
    logic                         r_bz;
    logic                         r_wr_valid;
    logic [ROW_W-1:0]             r_wr_row;
    logic [CMP_W-1:0]             r_best;

    logic [CMP_W-1:0]   tgt_ext;
    logic [CMP_W-1:0]   t_rows;
    logic [ROW_W-1:0]   top;
    logic [SH-1:0]      tmod;
    logic [W-1:0]       top_mask;
    logic [W-1:0]       rd_a;
    logic [W-1:0]       rd_b;
    logic [W-1:0]       lo_eff;
    logic [2*W-1:0]     win;
    logic [W-1:0]       upd_mask;
    logic [W-1:0]       scan_word;
    logic [SH-1:0]      scan_idx;
    logic               cnt_gt_pw;
    logic               we;
    logic [ROW_W-1:0]   waddr;
    logic [W-1:0]       wdata;
    logic [ROW_W-1:0]   raddr_b;

    assign tgt_ext   = CMP_W'(i_target);
    assign t_rows    = r_t >> SH;
    assign top       = t_rows[ROW_W-1:0];
    assign tmod      = r_t[SH-1:0];
    assign top_mask  = {W{1'b1}} >> (~tmod);
    assign lo_eff    = r_bz ? '0 : rd_b;
    assign win       = {r_hi, lo_eff} << r_s;
    assign upd_mask  = (r_wr_row == top) ? top_mask : {W{1'b1}};
    assign scan_word = rd_a & ((r_k == top) ? top_mask : {W{1'b1}});
    assign cnt_gt_pw = {1'b0, r_count} > r_pw;

    always_comb begin
        scan_idx = '0;
        for (int i = 0; i < W; i++) begin
            if (scan_word[i]) begin
                scan_idx = SH'(i);
            end
        end
    end

    always_comb begin
        raddr_b = r_k - r_q - ROW_W'(1);
        if (i_op == bssc_pkg::OP_PRIME) begin
            raddr_b = r_k - r_q;
        end
    end

    always_comb begin
        we    = r_wr_valid;
        waddr = r_wr_row;
        wdata = rd_a | (win[2*W-1:W] & upd_mask);
        if (i_op == bssc_pkg::OP_CLR) begin
            we    = 1'b1;
            waddr = r_k;
            wdata = (r_k == '0) ? W'(1) : '0;
        end
    end

    bssc_ram #(
        .WIDTH  (W),
        .DEPTH  (ROWS),
        .ADDR_W (ROW_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (r_k),
        .o_rdata_a (rd_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else begin
            r_wr_valid <= (i_op == bssc_pkg::OP_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            bssc_pkg::OP_LOAD: begin
                r_size  <= i_item_size;
                r_count <= i_item_count;
                r_last  <= i_last_group;
                r_pw    <= bssc_pkg::PW_W'(1);
                r_t     <= (tgt_ext > CMP_W'(MAX_SUM)) ? CMP_W'(MAX_SUM) : tgt_ext;
            end
            bssc_pkg::OP_SPLIT: begin
                r_k <= top;
                if (cnt_gt_pw) begin
                    r_factor <= r_pw;
                    r_count  <= r_count - r_pw[bssc_pkg::FIELD_W-1:0];
                    r_pw     <= r_pw << 1;
                end else begin
                    r_factor <= bssc_pkg::PW_W'(r_count);
                    r_count  <= '0;
                end
            end
            bssc_pkg::OP_MUL: begin
                r_chunk <= bssc_pkg::PROD_W'(r_factor) * bssc_pkg::PROD_W'(r_size);
            end
            bssc_pkg::OP_CHECK: begin
                r_q <= r_chunk[ROW_W+SH-1:SH];
                r_s <= r_chunk[SH-1:0];
            end
            bssc_pkg::OP_PRIME: begin
                r_bz <= 1'b0;
            end
            bssc_pkg::OP_RUN: begin
                r_hi     <= lo_eff;
                r_bz     <= (r_k == r_q);
                r_wr_row <= r_k;
                r_k      <= r_k - ROW_W'(1);
            end
            bssc_pkg::OP_SCAN_CHK: begin
                r_best <= CMP_W'({r_k, scan_idx});
                r_k    <= r_k - ROW_W'(1);
            end
            bssc_pkg::OP_CLR_INIT: begin
                r_k <= ROW_W'(ROWS - 1);
            end
            bssc_pkg::OP_CLR: begin
                r_k <= r_k - ROW_W'(1);
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_sts.have_chunk = (r_count != '0);
    assign o_sts.chunk_ok   = (r_chunk != '0) && (r_chunk <= bssc_pkg::PROD_W'(r_t));
    assign o_sts.run_last   = (r_k == r_q);
    assign o_sts.found      = (scan_word != '0);
    assign o_sts.clr_last   = (r_k == '0);
    assign o_sts.last       = r_last;
    assign o_best_sum       = r_best[bssc_pkg::FIELD_W-1:0];

endmodule
